### rtl/dnd_pkg.sv
// ----------------------------------------------------------------------------
// dnd_pkg
// Shared types and constants of the DNS name decompressor: item modes,
// read address selects, and the command and status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package dnd_pkg;

  localparam int ADDR_W   = 9;
  localparam int BYTE_W   = 8;
  localparam int LIMIT_W  = 10;
  localparam int PTR_W    = 14;
  localparam int CURSOR_W = 11;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 32;

  localparam logic [7:0] PTR_MASK    = 8'hc0;
  localparam logic [7:0] MARKER_BYTE = 8'd192;
  localparam logic [7:0] DOT_CHAR    = 8'h2e;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_DECODE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    RD_C   = 2'd0,
    RD_C1  = 2'd1,
    RD_T   = 2'd2,
    RD_SRC = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic    capture;
    logic    load_we;
    rd_sel_t rd_sel;
    logic    lab_load;
    logic    src_from_t;
    logic    t_load;
    logic    copy_step;
    logic    dot_write;
    logic    adv_t;
    logic    set_err;
    logic    set_done;
    logic    c_add2;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic c_lt_end;
    logic t_lt_end;
    logic byte_zero;
    logic byte_ptr;
    logic c_label_bad;
    logic t_label_bad;
    logic copy_last;
    logic byte_marker;
    logic stop;
  } dp_status_t;

endpackage

### rtl/dns_name_decompressor.sv
// ----------------------------------------------------------------------------
// dns_name_decompressor
// Loads a DNS packet byte by byte, decodes a compressed dotted name from it
// and returns the decoded name bytes on request.
// ----------------------------------------------------------------------------
// Load and no-op beats go from accept straight to the response step; a name read
// first reads the name store. Decode reads each label length, copies its bytes and
//   writes a dot; a pointer adds its low byte load and an end step, the marker check
//   a read and test per pointed label. One item at a time; output stalls lengthen the item,
//   and the walk is set by the single packet store read port, one byte per cycle while copying.
// Reset clears the sequencer, output valid and name count, not the stores.
module dns_name_decompressor #(
  parameter int PACKET_BYTES = 512,
  parameter int NAME_BYTES   = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [dnd_pkg::IN_W-1:0]  s_axis_tdata,  // address, data_byte, end_limit, stop_at_marker
  input  logic [1:0]                s_axis_tuser,  // mode
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [dnd_pkg::OUT_W-1:0] m_axis_tdata,  // name_length, next_address, label_completed, name_byte
  output logic                      m_axis_tuser   // status
);

  dnd_pkg::dp_cmd_t    cmd;
  dnd_pkg::dp_status_t flags;

  logic [7:0] name_length;
  logic [9:0] next_address;
  logic       label_completed;
  logic [7:0] name_byte;

  dnd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .mode    (s_axis_tuser),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .flags   (flags),
    .cmd     (cmd)
  );

  dnd_datapath #(
    .PACKET_BYTES (PACKET_BYTES),
    .NAME_BYTES   (NAME_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .flags           (flags),
    .mode            (s_axis_tuser),
    .address         (s_axis_tdata[8:0]),
    .data_byte       (s_axis_tdata[16:9]),
    .end_limit       (s_axis_tdata[26:17]),
    .stop_at_marker  (s_axis_tdata[27]),
    .status          (m_axis_tuser),
    .name_length     (name_length),
    .next_address    (next_address),
    .label_completed (label_completed),
    .name_byte       (name_byte)
  );

  assign m_axis_tdata = {5'd0, name_byte, label_completed, next_address, name_length};

endmodule

### rtl/dnd_ctrl.sv
// ----------------------------------------------------------------------------
// dnd_ctrl
// Sequencer of the name decompressor: dispatches each input beat by mode,
// steps the label and pointer walk, and owns the output valid.
// ----------------------------------------------------------------------------
module dnd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_valid,
  input  logic [1:0]          mode,
  output logic                s_ready,
  output logic                m_valid,
  input  logic                m_ready,
  input  dnd_pkg::dp_status_t flags,
  output dnd_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NREAD,
    ST_C_CHK,
    ST_C_BYTE,
    ST_P_LO,
    ST_T_CHK,
    ST_T_BYTE,
    ST_COPY,
    ST_COPY_LAST,
    ST_DOT,
    ST_T_MRD,
    ST_T_MARK,
    ST_P_END,
    ST_RESP
  } state_t;

  state_t state, state_next;
  logic   in_ptr, in_ptr_next;
  logic   accept;
  logic   out_free;

  assign s_ready  = (state == ST_IDLE);
  assign accept   = s_valid && s_ready;
  assign out_free = !m_valid || m_ready;

  always_comb begin
    state_next  = state;
    in_ptr_next = in_ptr;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          in_ptr_next = 1'b0;
          case (dnd_pkg::mode_t'(mode))
            dnd_pkg::MODE_LOAD: begin
              cmd.load_we = 1'b1;
              state_next  = ST_RESP;
            end
            dnd_pkg::MODE_DECODE: state_next = ST_C_CHK;
            dnd_pkg::MODE_READ:   state_next = ST_NREAD;
            default:              state_next = ST_RESP;
          endcase
        end
      end
      ST_NREAD: state_next = ST_RESP;
      ST_C_CHK: begin
        cmd.rd_sel = dnd_pkg::RD_C;
        state_next = flags.c_lt_end ? ST_C_BYTE : ST_RESP;
      end
      ST_C_BYTE: begin
        cmd.rd_sel = dnd_pkg::RD_C1;
        if (flags.byte_zero) begin
          state_next = ST_RESP;
        end else if (flags.byte_ptr) begin
          cmd.lab_load = 1'b1;
          state_next   = ST_P_LO;
        end else if (flags.c_label_bad) begin
          cmd.set_err = 1'b1;
          state_next  = ST_RESP;
        end else begin
          cmd.lab_load = 1'b1;
          state_next   = ST_COPY;
        end
      end
      ST_P_LO: begin
        cmd.t_load  = 1'b1;
        in_ptr_next = 1'b1;
        state_next  = ST_T_CHK;
      end
      ST_T_CHK: begin
        cmd.rd_sel = dnd_pkg::RD_T;
        state_next = flags.t_lt_end ? ST_T_BYTE : ST_P_END;
      end
      ST_T_BYTE: begin
        if (flags.byte_zero) begin
          state_next = ST_P_END;
        end else if (flags.t_label_bad) begin
          cmd.set_err = 1'b1;
          state_next  = ST_RESP;
        end else begin
          cmd.lab_load   = 1'b1;
          cmd.src_from_t = 1'b1;
          state_next     = ST_COPY;
        end
      end
      ST_COPY: begin
        cmd.rd_sel    = dnd_pkg::RD_SRC;
        cmd.copy_step = 1'b1;
        if (flags.copy_last) begin
          state_next = ST_COPY_LAST;
        end
      end
      ST_COPY_LAST: state_next = ST_DOT;
      ST_DOT: begin
        cmd.dot_write = 1'b1;
        cmd.adv_t     = in_ptr;
        if (!in_ptr) begin
          state_next = ST_C_CHK;
        end else if (flags.stop) begin
          state_next = ST_T_MRD;
        end else begin
          state_next = ST_T_CHK;
        end
      end
      ST_T_MRD: begin
        cmd.rd_sel = dnd_pkg::RD_T;
        state_next = ST_T_MARK;
      end
      ST_T_MARK: begin
        if (flags.byte_marker) begin
          cmd.set_done = 1'b1;
          state_next   = ST_P_END;
        end else begin
          state_next = ST_T_CHK;
        end
      end
      ST_P_END: begin
        cmd.c_add2 = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      in_ptr  <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      state  <= state_next;
      in_ptr <= in_ptr_next;
      if (cmd.out_load) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_out_no_clobber: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_valid || m_ready))
    else $error("result register loaded while a beat is still held");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_valid && s_ready) |=> (state != ST_IDLE))
    else $error("accepted beat did not start any work");

  a_valid_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(m_valid) |-> ($past(state) == ST_RESP))
    else $error("output valid raised outside the response step");
`endif

endmodule

### rtl/dnd_datapath.sv
// ----------------------------------------------------------------------------
// dnd_datapath
// Packet and name byte stores, walk cursors and result register of the
// name decompressor; acts on commands from the sequencer.
// ----------------------------------------------------------------------------
module dnd_datapath #(
  parameter int PACKET_BYTES = 512,
  parameter int NAME_BYTES   = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dnd_pkg::dp_cmd_t           cmd,
  output dnd_pkg::dp_status_t        flags,
  input  logic [1:0]                 mode,
  input  logic [dnd_pkg::ADDR_W-1:0] address,
  input  logic [dnd_pkg::BYTE_W-1:0] data_byte,
  input  logic [dnd_pkg::LIMIT_W-1:0] end_limit,
  input  logic                       stop_at_marker,
  output logic                       status,
  output logic [7:0]                 name_length,
  output logic [dnd_pkg::LIMIT_W-1:0] next_address,
  output logic                       label_completed,
  output logic [dnd_pkg::BYTE_W-1:0] name_byte
);

  localparam int PA = $clog2(PACKET_BYTES);
  localparam int NW = $clog2(NAME_BYTES);
  localparam int DW = $clog2(NAME_BYTES + 1);
  localparam int SW = ((DW > 8) ? DW : 8) + 1;
  localparam int CW = dnd_pkg::CURSOR_W;
  localparam int TW = dnd_pkg::PTR_W;
  localparam int RW = 19;

  function automatic logic [PA-1:0] pkt_wrap(input logic [CW-1:0] a);
    logic [RW-1:0] r;
    r = RW'(a);
    for (int k = 6; k >= 0; k--) begin
      if (r >= (RW'(PACKET_BYTES) << k)) begin
        r = r - (RW'(PACKET_BYTES) << k);
      end
    end
    return PA'(r);
  endfunction

  logic [7:0] packet_store [PACKET_BYTES];
  logic [7:0] name_store   [NAME_BYTES];

  dnd_pkg::mode_t             item_mode;
  logic [dnd_pkg::ADDR_W-1:0] start_addr;
  logic [dnd_pkg::LIMIT_W-1:0] end_addr;
  logic                       stop_flag;
  logic [CW-1:0]              c;
  logic [TW-1:0]              t;
  logic [DW-1:0]              d;
  logic [7:0]                 len;
  logic [CW-1:0]              src;
  logic [7:0]                 i;
  logic                       pv;
  logic                       err;
  logic                       done;
  logic [7:0]                 name_count;
  logic [7:0]                 pkt_rdata;
  logic [7:0]                 name_rdata;

  logic [CW-1:0] rd_addr;
  logic [11:0]   label_end;
  logic [SW-1:0] name_sum;
  logic          name_full;
  logic          name_we;
  logic [NW-1:0] name_widx;
  logic [7:0]    name_wdata;
  logic [7:0]    count_next;
  logic          is_decode;
  logic          is_read;

  always_comb begin
    case (cmd.rd_sel)
      dnd_pkg::RD_C:   rd_addr = c;
      dnd_pkg::RD_C1:  rd_addr = c + CW'(1);
      dnd_pkg::RD_T:   rd_addr = t[CW-1:0];
      dnd_pkg::RD_SRC: rd_addr = src + CW'(i);
      default:         rd_addr = c;
    endcase
  end

  assign label_end = 12'(c) + 12'(pkt_rdata);
  assign name_sum  = SW'(d) + SW'(pkt_rdata);
  assign name_full = (name_sum >= SW'(NAME_BYTES));

  assign flags.c_lt_end    = (c < CW'(end_addr));
  assign flags.t_lt_end    = (t < TW'(end_addr));
  assign flags.byte_zero   = (pkt_rdata == 8'd0);
  assign flags.byte_ptr    = ((pkt_rdata & dnd_pkg::PTR_MASK) != 8'd0);
  assign flags.c_label_bad = (label_end >= 12'(end_addr)) || name_full;
  assign flags.t_label_bad = name_full;
  assign flags.copy_last   = ((i + 8'd1) == len);
  assign flags.byte_marker = (pkt_rdata == dnd_pkg::MARKER_BYTE);
  assign flags.stop        = stop_flag;

  assign name_we    = pv || cmd.dot_write;
  assign name_wdata = pv ? pkt_rdata : dnd_pkg::DOT_CHAR;
  assign name_widx  = pv ? NW'(SW'(d) + SW'(i) - SW'(1)) : NW'(SW'(d) + SW'(len));

  assign is_decode  = (item_mode == dnd_pkg::MODE_DECODE);
  assign is_read    = (item_mode == dnd_pkg::MODE_READ);
  assign count_next = (err || (d == '0)) ? 8'd0 : 8'(d - DW'(1));

  // packet and name stores
  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      packet_store[pkt_wrap(CW'(address))] <= data_byte;
    end
    pkt_rdata <= packet_store[pkt_wrap(rd_addr)];
    if (name_we) begin
      name_store[name_widx] <= name_wdata;
    end
    name_rdata <= name_store[NW'(start_addr)];
  end

  // walk registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode  <= dnd_pkg::mode_t'(mode);
      start_addr <= address;
      end_addr   <= end_limit;
      stop_flag  <= stop_at_marker;
      c          <= CW'(address);
      d          <= '0;
    end
    if (cmd.lab_load) begin
      len <= pkt_rdata;
      src <= (cmd.src_from_t ? t[CW-1:0] : c) + CW'(1);
      i   <= 8'd0;
    end
    if (cmd.t_load) begin
      t <= {len[5:0], pkt_rdata};
    end
    if (cmd.copy_step) begin
      i <= i + 8'd1;
    end
    if (cmd.dot_write) begin
      d <= DW'(SW'(d) + SW'(len) + SW'(1));
      if (cmd.adv_t) begin
        t <= t + TW'(len) + TW'(1);
      end else begin
        c <= c + CW'(len) + CW'(1);
      end
    end
    if (cmd.c_add2) begin
      c <= c + CW'(2);
    end
    if (cmd.out_load) begin
      status          <= is_decode && err;
      name_length     <= is_decode ? count_next : name_count;
      next_address    <= is_decode ? c[dnd_pkg::LIMIT_W-1:0] : '0;
      label_completed <= is_decode && done;
      name_byte       <= (is_read && (start_addr < 9'(name_count))) ? name_rdata : 8'd0;
    end
  end

  // control flags and name count
  always_ff @(posedge clk) begin
    if (rst) begin
      pv         <= 1'b0;
      err        <= 1'b0;
      done       <= 1'b0;
      name_count <= 8'd0;
    end else begin
      pv <= cmd.copy_step;
      if (cmd.capture) begin
        err  <= 1'b0;
        done <= 1'b0;
      end
      if (cmd.set_err) begin
        err <= 1'b1;
      end
      if (cmd.set_done) begin
        done <= 1'b1;
      end
      if (cmd.out_load && is_decode) begin
        name_count <= count_next;
      end
    end
  end

`ifndef SYNTH
  a_one_name_write: assert property (@(posedge clk) disable iff (rst)
    cmd.dot_write |-> !pv)
    else $error("label byte and dot written in the same cycle");

  a_name_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.dot_write |=> (d <= DW'(NAME_BYTES)))
    else $error("name length ran past the name store");

  a_copy_in_label: assert property (@(posedge clk) disable iff (rst)
    cmd.copy_step |-> (i < len))
    else $error("label copy issued past the label length");
`endif

endmodule

### tb/sv/tb_dns_name_decompressor.sv
// ----------------------------------------------------------------------------
// tb_dns_name_decompressor
// Streams packet loads, name decodes and name reads into the decompressor
// and checks every result beat against a cycle-free model of the name walk.
// A short directed packet covers plain labels, pointers, the 192 marker,
// a label past the end limit, empty names and reads out of range. After it
// the whole packet store is filled and random well-formed names, pointer
// chains at the edge of the name store and random noise follow, with random
// gaps on both sides of the block.
// ----------------------------------------------------------------------------
module tb_dns_name_decompressor;

  localparam int PKT          = 512;
  localparam int NAME         = 256;
  localparam int ITEM_TARGET  = 1500;
  localparam int TAIL_CYCLES  = 64;
  localparam int PRINT_LIMIT  = 200;

  typedef struct packed {
    dnd_pkg::mode_t mode;
    logic [8:0]     address;
    logic [7:0]     data_byte;
    logic [9:0]     end_limit;
    logic           stop_at_marker;
  } dns_item_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  name_length;
    logic [9:0]  next_address;
    logic        label_completed;
    logic [7:0]  name_byte;
  } dns_result_t;

  typedef struct packed {
    logic        err;
    logic        done;
    logic        safe;
    logic [9:0]  next_address;
    logic [7:0]  length;
  } walk_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [dnd_pkg::IN_W-1:0]  s_axis_tdata = '0;   // address, data_byte, end_limit, stop_at_marker
  logic [1:0]                s_axis_tuser = '0;   // mode
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [dnd_pkg::OUT_W-1:0] m_axis_tdata;        // name_length, next_address, label_completed, name_byte
  logic                      m_axis_tuser;        // status

  dns_item_t   items_to_send[$];
  dns_result_t outcomes_due[$];
  dns_item_t   beat_item;

  // model state, advanced as items are accepted
  logic [PKT-1:0][7:0]  model_packet;
  logic [NAME-1:0][7:0] model_name;
  logic [7:0]           model_count = '0;

  // packet image as planned, used to keep decodes off unwritten bytes
  logic [PKT-1:0][7:0]  plan_packet = '0;
  logic [PKT-1:0]       plan_known = '0;
  int unsigned          planned = 0;
  int unsigned          last_length = 0;
  int unsigned          name_starts[$];

  int unsigned items_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  logic        steady_in;
  logic        steady_out;

  dns_name_decompressor #(
    .PACKET_BYTES(PKT),
    .NAME_BYTES(NAME)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assign steady_in  = items_accepted >= 700 && items_accepted < 1000;
  assign steady_out = results_seen >= 700 && results_seen < 1000;

  function automatic logic [7:0] peek(input logic [PKT-1:0][7:0] img,
                                      input logic [PKT-1:0] known,
                                      input int unsigned a, inout logic ok);
    ok = ok & known[a % PKT];
    return img[a % PKT];
  endfunction

  function automatic walk_t walk_name(input logic [PKT-1:0][7:0] img,
                                      input logic [PKT-1:0] known,
                                      input dns_item_t it,
                                      output logic [NAME-1:0][7:0] nm);
    walk_t       w;
    int unsigned c, d, t, len, i;
    logic [7:0]  b;
    logic        ok;
    w  = '0;
    nm = '0;
    ok = 1'b1;
    c  = it.address;
    d  = 0;
    while (c < it.end_limit) begin
      b = peek(img, known, c, ok);
      if (b == 8'd0) break;
      if ((b & dnd_pkg::PTR_MASK) != 8'd0) begin
        // one level of pointer: every byte there is a plain length
        t = {b[5:0], peek(img, known, c + 1, ok)};
        while (t < it.end_limit) begin
          len = peek(img, known, t, ok);
          if (len == 0) break;
          if (d + len >= NAME) begin
            w.err = 1'b1;
            break;
          end
          for (i = 0; i < len; i++) nm[d + i] = peek(img, known, t + 1 + i, ok);
          nm[d + len] = dnd_pkg::DOT_CHAR;
          d += len + 1;
          t += len + 1;
          if (it.stop_at_marker && peek(img, known, t, ok) == dnd_pkg::MARKER_BYTE) begin
            w.done = 1'b1;
            break;
          end
        end
        if (!w.err) c += 2;
        break;
      end
      if (c + b >= it.end_limit || d + b >= NAME) begin
        w.err = 1'b1;
        break;
      end
      for (i = 0; i < b; i++) nm[d + i] = peek(img, known, c + 1 + i, ok);
      nm[d + b] = dnd_pkg::DOT_CHAR;
      d += b + 1;
      c += b + 1;
    end
    if (w.err) d = 0;
    else if (d > 0) d--;
    w.length       = 8'(d);
    w.next_address = 10'(c);
    w.safe         = ok;
    return w;
  endfunction

  function automatic dns_result_t expected_outcome(input dns_item_t it);
    dns_result_t          r;
    walk_t                w;
    logic [NAME-1:0][7:0] nm;
    r = '0;
    case (it.mode)
      dnd_pkg::MODE_LOAD: begin
        model_packet[it.address] = it.data_byte;
      end
      dnd_pkg::MODE_READ: begin
        if (it.address < model_count) r.name_byte = model_name[it.address];
      end
      dnd_pkg::MODE_DECODE: begin
        w = walk_name(model_packet, '1, it, nm);
        model_name        = nm;
        model_count       = w.length;
        r.status          = w.err;
        r.next_address    = w.next_address;
        r.label_completed = w.done;
      end
      default: ;
    endcase
    r.name_length = model_count;
    return r;
  endfunction

  function automatic dns_item_t make_item(input dnd_pkg::mode_t m, input int unsigned a,
                                          input logic [7:0] db, input logic [9:0] lim,
                                          input logic stop);
    dns_item_t it;
    it.mode           = m;
    it.address        = 9'(a % PKT);
    it.data_byte      = db;
    it.end_limit      = lim;
    it.stop_at_marker = stop;
    return it;
  endfunction

  task automatic plan(input dns_item_t it);
    if (it.mode == dnd_pkg::MODE_LOAD) begin
      plan_packet[it.address] = it.data_byte;
      plan_known[it.address]  = 1'b1;
    end
    items_to_send.push_back(it);
    planned++;
  endtask

  task automatic plan_load(input int unsigned a, input logic [7:0] v);
    plan(make_item(dnd_pkg::MODE_LOAD, a, v, 10'($urandom_range(0, PKT)), 1'($urandom)));
  endtask

  task automatic plan_read(input int unsigned idx);
    plan(make_item(dnd_pkg::MODE_READ, idx, 8'($urandom), 10'($urandom_range(0, PKT)),
                   1'($urandom)));
  endtask

  // decodes that would touch an unwritten packet byte are dropped
  task automatic plan_decode(input int unsigned a, input int unsigned lim,
                             input logic stop, output logic ok);
    dns_item_t            it;
    walk_t                w;
    logic [NAME-1:0][7:0] scratch;
    it = make_item(dnd_pkg::MODE_DECODE, a, 8'($urandom), 10'(lim), stop);
    w  = walk_name(plan_packet, plan_known, it, scratch);
    ok = w.safe;
    if (ok) begin
      last_length = w.length;
      plan(it);
    end
  endtask

  task automatic plan_well_formed();
    int unsigned base, p, nlab, len, k, j, tgt, lim, nreads;
    logic [1:0]  pfx;
    logic        ok;
    base = $urandom_range(0, PKT - 1);
    p    = base;
    nlab = $urandom_range(0, 4);
    for (k = 0; k < nlab; k++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 63) : $urandom_range(1, 12);
      plan_load(p, 8'(len));
      p++;
      for (j = 0; j < len; j++) begin
        plan_load(p, 8'($urandom));
        p++;
      end
    end
    case ($urandom_range(0, 2))
      0: plan_load(p, 8'd0);
      1: begin
        if (name_starts.size() > 0 && $urandom_range(0, 3) != 0)
          tgt = name_starts[$urandom_range(0, name_starts.size() - 1)];
        else
          tgt = $urandom_range(0, PKT - 1);
        pfx = 2'($urandom_range(1, 3));
        plan_load(p, {pfx, 6'(tgt >> 8)});
        plan_load(p + 1, 8'(tgt));
      end
      default: begin
        plan_load(p, dnd_pkg::MARKER_BYTE);
        plan_load(p + 1, 8'd0);
      end
    endcase
    name_starts.push_back(base);
    lim = ($urandom_range(0, 1) == 0) ? PKT : $urandom_range(base, PKT);
    plan_decode(base, lim, 1'($urandom), ok);
    if (ok) begin
      nreads = $urandom_range(0, 3);
      for (k = 0; k < nreads; k++) plan_read($urandom_range(0, last_length + 1));
    end
  endtask

  // pointer to two long labels whose sum sits at the edge of the name store
  task automatic plan_long_chain();
    int unsigned l1, l2, tgt, base;
    logic        ok;
    l1   = $urandom_range(100, 254);
    l2   = 254 - l1 + $urandom_range(0, 1);
    tgt  = $urandom_range(0, 230);
    base = tgt + l1 + l2 + 3 + $urandom_range(0, 20);
    plan_load(tgt, 8'(l1));
    plan_load(tgt + l1 + 1, 8'(l2));
    plan_load(tgt + l1 + l2 + 2, 8'd0);
    plan_load(base, {2'b11, 6'(tgt >> 8)});
    plan_load(base + 1, 8'(tgt));
    plan_decode(base, PKT, 1'b0, ok);
    if (ok) begin
      plan_read(254);
      plan_read($urandom_range(0, 255));
    end
  endtask

  task automatic plan_random_step();
    int unsigned pick, tries;
    logic        ok;
    pick = $urandom_range(0, 99);
    if (pick < 55) plan_well_formed();
    else if (pick < 65) plan_long_chain();
    else if (pick < 85) begin
      ok = 1'b0;
      for (tries = 0; tries < 8 && !ok; tries++)
        plan_decode($urandom_range(0, PKT - 1), $urandom_range(0, PKT), 1'($urandom), ok);
    end else if (pick < 93) begin
      if ($urandom_range(0, 1) == 0) plan_read($urandom_range(0, PKT - 1));
      else plan_read($urandom_range(0, last_length));
    end else if (pick < 98) plan_load($urandom_range(0, PKT - 1), 8'($urandom));
    else
      plan(make_item(dnd_pkg::MODE_NONE, $urandom_range(0, PKT - 1), 8'($urandom),
                     10'($urandom_range(0, PKT)), 1'($urandom)));
  endtask

  task automatic wait_until_drained();
    while (items_to_send.size() != 0 || s_axis_tvalid || outcomes_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch at result %0d: %s expected %0d got %0d",
               results_seen, what, want, got);
    mismatches++;
  endtask

  task automatic check_result();
    dns_result_t want;
    if (outcomes_due.size() == 0) begin
      report_mismatch("beat with nothing outstanding", 0, 1);
    end else begin
      want = outcomes_due.pop_front();
      if (m_axis_tuser !== want.status)
        report_mismatch("status", want.status, m_axis_tuser);
      if (m_axis_tdata[7:0] !== want.name_length)
        report_mismatch("name_length", want.name_length, m_axis_tdata[7:0]);
      if (m_axis_tdata[17:8] !== want.next_address)
        report_mismatch("next_address", want.next_address, m_axis_tdata[17:8]);
      if (m_axis_tdata[18] !== want.label_completed)
        report_mismatch("label_completed", want.label_completed, m_axis_tdata[18]);
      if (m_axis_tdata[26:19] !== want.name_byte)
        report_mismatch("name_byte", want.name_byte, m_axis_tdata[26:19]);
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        outcomes_due.push_back(expected_outcome(beat_item));
        items_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (items_to_send.size() != 0 && (steady_in || $urandom_range(0, 99) >= 25)) begin
          beat_item = items_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'd0, beat_item.stop_at_marker, beat_item.end_limit,
                            beat_item.data_byte, beat_item.address};
          s_axis_tuser  <= beat_item.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      m_axis_tready <= steady_out || $urandom_range(0, 99) >= 25;
    end
  end

  initial begin
    #100_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned a;
    logic        ok;
    // packet: "ab" at 0, "x" plus pointer to 0 at 4, pointer to "q" then marker at 8
    plan_load(0, 8'd2);
    plan_load(1, 8'h61);
    plan_load(2, 8'h62);
    plan_load(3, 8'd0);
    plan_load(4, 8'd1);
    plan_load(5, 8'h78);
    plan_load(6, 8'hc0);
    plan_load(7, 8'h00);
    plan_load(8, 8'hc0);
    plan_load(9, 8'h0c);
    plan_load(12, 8'd1);
    plan_load(13, 8'h71);
    plan_load(14, dnd_pkg::MARKER_BYTE);
    plan_decode(0, PKT, 1'b0, ok);
    plan_read(0);
    plan_read(1);
    plan_read(2);
    plan_decode(4, PKT, 1'b0, ok);
    plan_read(3);
    plan_read(PKT - 1);
    plan_decode(8, PKT, 1'b1, ok);
    plan_decode(0, 2, 1'b0, ok);
    plan_decode(3, PKT, 1'b1, ok);
    plan_decode(0, 0, 1'b0, ok);
    plan(make_item(dnd_pkg::MODE_NONE, 0, 8'd0, 10'd0, 1'b0));
    name_starts.push_back(0);
    name_starts.push_back(4);
    name_starts.push_back(12);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // hold off until the directed part has fully come back
    wait_until_drained();
    for (a = 0; a < PKT; a++) plan_load(a, 8'($urandom));
    while (planned < 1000) plan_random_step();
    wait_until_drained();
    while (planned < ITEM_TARGET) plan_random_step();
    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (outcomes_due.size() != 0)
      report_mismatch("results never returned", 0, outcomes_due.size());
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### dns_name_decompressor.f
rtl/dnd_pkg.sv
rtl/dnd_ctrl.sv
rtl/dnd_datapath.sv
rtl/dns_name_decompressor.sv
tb/sv/tb_dns_name_decompressor.sv
